>>> design/ais_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_pkg: shared types and constants of the ascending integer sorter
// Holds the transaction payload types, the cell control bundle and the
// controller state encoding.
// ----------------------------------------------------------------------------
package ais_pkg;

	localparam int VALUE_BITS = 32;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	// Input transaction payload
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value_in;
		logic                         last_in;
	} item_t;

	// Output transaction payload
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value_out;
		logic                         last_out;
		logic                         overflowed;
	} result_t;

	// Broadcast control from the controller to every cell
	typedef struct packed {
		logic                         insert;
		logic                         shift;
		logic signed [VALUE_BITS-1:0] new_value;
	} cell_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

>>> design/ascending_integer_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_integer_sorter: insertion-sorting chain of DEPTH cells
// Collects a run of signed values and returns it in ascending order.
//
// Input channel (item_valid/item_ready, payload item): one value per
// transaction; last_in closes the run. Each value is inserted into the sorted
// cell row on acceptance; item_ready stays high while loading. Items arriving
// while all DEPTH cells are full are dropped and flag the run as overflowed.
// After the last item the block drains: the next cycle cell 0 holds the
// smallest value and result_valid rises; one result transaction per cycle
// leaves while result_ready is high, the row shifting toward cell 0 on each.
// last_out marks the largest value; overflowed is set on every result of a
// run that dropped items. item_ready is low during the drain. A stalled
// receiver simply holds the row: the result payload stays put until taken.
// Reset empties every cell and clears the count and overflow flag.
// ----------------------------------------------------------------------------
module ascending_integer_sorter #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ais_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output ais_pkg::result_t result
);
	import ais_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	cell_ctrl_t       ctrl;
	logic             item_acc, result_acc, full;

	value_t           cell_value [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] cell_gt;

	assign item_acc   = item_valid && item_ready;
	assign result_acc = result_valid && result_ready;
	assign full       = (count_q == CNT_W'(DEPTH));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (item_acc && item.last_in) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (result_acc && result.last_out) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Outputs and cell control
	always_comb begin
		item_ready     = 1'b0;
		result_valid   = 1'b0;
		ctrl.insert    = 1'b0;
		ctrl.shift     = 1'b0;
		ctrl.new_value = item.value_in;
		unique case (state_q)
			ST_LOAD: begin
				item_ready  = 1'b1;
				ctrl.insert = item_valid && !full;
			end
			ST_DRAIN: begin
				result_valid = cell_valid[0];
				ctrl.shift   = result_ready && cell_valid[0];
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	assign result.value_out  = cell_value[0];
	assign result.last_out   = !cell_valid[1];
	assign result.overflowed = ovf_q;

	// Controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRAIN && result_acc && result.last_out) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (item_acc) begin
				if (full) ovf_q <= 1'b1;
				else      count_q <= count_q + 1'b1;
			end
		end
	end

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		value_t l_value, r_value;
		logic   l_valid, l_gt, r_valid;

		if (i == 0) begin : g_first
			assign l_value = '0;
			assign l_valid = 1'b0;
			assign l_gt    = 1'b0;
		end else begin : g_mid
			assign l_value = cell_value[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_gt    = cell_gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_value = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_value = cell_value[i+1];
			assign r_valid = cell_valid[i+1];
		end

		ais_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_value  (l_value),
			.left_valid  (l_valid),
			.left_gt     (l_gt),
			.right_value (r_value),
			.right_valid (r_valid),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.gt          (cell_gt[i])
		);
	end

	// While loading, occupied cells always match the held count
	a_fill_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> ($countones(cell_valid) == int'(count_q)))
		else $error("cell occupancy differs from count");

	// The last item always leaves something to emit
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.last_in) |=> result_valid)
		else $error("no result after last item");

	// A full row stays full when an item is dropped
	a_drop_keeps_full: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && full) |=> (full && ovf_q))
		else $error("dropped item changed the row");

	// Final result empties the block
	a_drain_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_acc && result.last_out) |=>
			(state_q == ST_LOAD && count_q == '0 && !ovf_q && cell_valid == '0))
		else $error("block not empty after final result");

endmodule

>>> design/ais_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_cell: one slot of the sorting chain
// Holds one value and its valid bit. On insert it keeps its value, takes the
// broadcast value or takes its left neighbor's value so the row stays sorted.
// On shift it takes its right neighbor's value (drain toward cell 0).
// ----------------------------------------------------------------------------
module ais_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ais_pkg::cell_ctrl_t ctrl,
	input  ais_pkg::value_t     left_value,
	input  logic                left_valid,
	input  logic                left_gt,
	input  ais_pkg::value_t     right_value,
	input  logic                right_valid,
	output ais_pkg::value_t     value,
	output logic                valid,
	output logic                gt
);
	import ais_pkg::*;

	value_t value_q;
	logic   valid_q;

	// Empty slot or held value above the new one: new value lands here or left
	assign gt    = !valid_q || (value_q > ctrl.new_value);
	assign value = value_q;
	assign valid = valid_q;

	// Value register
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right_value;
		end else if (ctrl.insert && gt) begin
			value_q <= left_gt ? left_value : ctrl.new_value;
		end
	end

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.insert && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

endmodule

>>> verif/tb_ascending_integer_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascending_integer_sorter: self-checking bench for the ascending sorter
// Feeds runs of signed values through the item channel and checks every
// result transaction against a behavioral sorter kept in the bench. Covers
// single-value runs, sign and range extremes, repeated values, full and
// overflowing runs (the closing item dropped too), under three idle profiles
// on both channels, with a full drain between profiles.
// ----------------------------------------------------------------------------
module tb_ascending_integer_sorter;

	import ais_pkg::*;

	localparam int DEPTH      = 16;
	localparam int HALF_CLK   = 4;
	localparam int RESET_CYC  = 5;
	localparam int ITEMS_EACH = 165;
	localparam int TAIL_CYC   = 2 * DEPTH + 8;

	localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// Pending stimulus, behavioral sorter state and expected results
	item_t   pending_items[$];
	value_t  held_values[$];
	bit      run_dropped;
	result_t sorted_results_q[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  item_taken;
	int  fail_count;
	int  items_accepted;
	int  runs_closed;
	int  overflow_runs;
	int  results_checked;

	ascending_integer_sorter #(
		.DEPTH(DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #HALF_CLK clk = ~clk;

	// Collect one accepted value; on the closing item sort the run and queue
	// its results, smallest first
	task automatic collect_and_sort(input item_t it);
		value_t  cur;
		int      j;
		result_t r;
		if (held_values.size() < DEPTH) begin
			held_values.push_back(it.value_in);
		end else begin
			run_dropped = 1'b1;
		end
		if (it.last_in) begin
			for (int i = 1; i < held_values.size(); i++) begin
				cur = held_values[i];
				j   = i;
				while (j > 0 && held_values[j-1] > cur) begin
					held_values[j] = held_values[j-1];
					j--;
				end
				held_values[j] = cur;
			end
			foreach (held_values[k]) begin
				r.value_out  = held_values[k];
				r.last_out   = (k == held_values.size() - 1);
				r.overflowed = run_dropped;
				sorted_results_q.push_back(r);
			end
			runs_closed++;
			if (run_dropped)
				overflow_runs++;
			held_values.delete();
			run_dropped = 1'b0;
		end
	endtask

	// Random value: mostly full range, some extremes and a narrow band so
	// that repeats show up
	function automatic value_t pick_value();
		case ($urandom_range(9))
			0:       return VALUE_MIN;
			1:       return VALUE_MAX;
			2, 3:    return value_t'($signed($urandom_range(14)) - 7);
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic queue_value(input value_t v, input bit last);
		item_t it;
		it.value_in = v;
		it.last_in  = last;
		pending_items.push_back(it);
	endtask

	// Random runs: mostly partial, some exactly full, some overflowing
	task automatic queue_random_runs(input int n_items);
		int queued;
		int len;
		int sel;
		queued = 0;
		while (queued < n_items) begin
			sel = $urandom_range(99);
			if (sel < 70)
				len = $urandom_range(DEPTH, 1);
			else if (sel < 85)
				len = DEPTH;
			else
				len = $urandom_range(DEPTH + 6, DEPTH + 1);
			for (int i = 0; i < len; i++)
				queue_value(pick_value(), i == len - 1);
			queued += len;
		end
	endtask

	// Sender holds off until every queued item is taken and every result is back
	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || sorted_results_q.size() != 0)
			@(posedge clk);
	endtask

	// Item and ready driver: new transaction or idle, and result_ready, at the falling edge
	always @(negedge clk) begin : item_drive
		logic  nxt_valid;
		item_t nxt_item;
		nxt_valid = item_valid;
		nxt_item  = item;
		if (!arst_n) begin
			nxt_valid    = 1'b0;
			result_ready <= 1'b0;
		end else begin
			if (item_taken)
				nxt_valid = 1'b0;
			item_taken = 1'b0;
			if (!nxt_valid && pending_items.size() != 0 &&
			    $urandom_range(99) >= send_idle_pct) begin
				nxt_item  = pending_items.pop_front();
				nxt_valid = 1'b1;
			end
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
		item_valid <= nxt_valid;
		item       <= nxt_item;
	end

	// Monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin : xfer_monitor
		result_t want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				collect_and_sort(item);
				items_accepted++;
				item_taken = 1'b1;
			end
			if (result_valid && result_ready) begin
				if (sorted_results_q.size() == 0) begin
					$display("%0t: unexpected result value_out %0d last_out %0b overflowed %0b",
						$time, result.value_out, result.last_out, result.overflowed);
					fail_count++;
				end else begin
					want = sorted_results_q.pop_front();
					if (result.value_out !== want.value_out) begin
						$display("%0t: value_out expected %0d, got %0d",
							$time, want.value_out, result.value_out);
						fail_count++;
					end
					if (result.last_out !== want.last_out) begin
						$display("%0t: last_out expected %0b, got %0b",
							$time, want.last_out, result.last_out);
						fail_count++;
					end
					if (result.overflowed !== want.overflowed) begin
						$display("%0t: overflowed expected %0b, got %0b",
							$time, want.overflowed, result.overflowed);
						fail_count++;
					end
				end
				results_checked++;
			end
		end
	end

	// Stimulus sequence and end of run
	initial begin
		send_idle_pct = 23;
		recv_idle_pct = 86;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;

		// Single-value runs at both extremes
		queue_value(VALUE_MIN, 1'b1);
		queue_value(VALUE_MAX, 1'b1);
		// Around the sign boundary, with a repeat
		queue_value(VALUE_MAX, 1'b0);
		queue_value(-1, 1'b0);
		queue_value(0, 1'b0);
		queue_value(-1, 1'b1);
		// Seventeen items: store fills, the closing item is dropped
		for (int i = 0; i < DEPTH + 1; i++)
			queue_value(value_t'((i % 3 == 0) ? VALUE_MAX - i : 7 - 2 * i), i == DEPTH);
		// Hold the sender until the directed runs are fully returned
		wait_drained();

		queue_random_runs(ITEMS_EACH);
		wait_drained();

		send_idle_pct = 86;
		recv_idle_pct = 23;
		queue_random_runs(ITEMS_EACH);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_runs(ITEMS_EACH);
		wait_drained();

		// Catch any stray result after the last expected one
		repeat (TAIL_CYC) @(posedge clk);

		$display("Ran %0d runs from %0d items, %0d of them overflowing.",
			runs_closed, items_accepted, overflow_runs);
		$display("Checked %0d sorted results under three idle profiles.", results_checked);
		if (fail_count == 0 && sorted_results_q.size() == 0) begin
			$display("ascending_integer_sorter regression: pass");
		end else begin
			$display("ascending_integer_sorter regression: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d results still outstanding", $time, sorted_results_q.size());
		$display("ascending_integer_sorter regression: fail");
		$finish;
	end

endmodule

>>> ascending_integer_sorter.f
design/ais_pkg.sv
design/ais_cell.sv
design/ascending_integer_sorter.sv
verif/tb_ascending_integer_sorter.sv
